### hw/rtl/jdn_pkg.sv
package jdn_pkg;

	localparam int N_STAGES = 5;

	// Astronomical year (AD y is y, y BC is 1 - y) and signed day counts.
	typedef logic signed [15:0] yr_t;
	typedef logic signed [25:0] dn_t;

	typedef enum logic {
		CMD_TO_SERIAL = 1'b0,
		CMD_TO_DATE   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_DATE  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef struct packed {
		logic [N_STAGES-1:0] en;
	} pipe_ctrl_t;

	// Serial day of 1 January 45 BC.
	localparam dn_t EPOCH_DAY = -26'sd735601;

	// Floor of v / 3 for v below 64.
	function automatic logic [4:0] div3(input logic [5:0] v);
		logic [11:0] p;
		p = 12'(v) * 12'd43;
		return p[11:7];
	endfunction

	function automatic logic is_leap(input yr_t y);
		yr_t v;
		logic [5:0] r;
		logic ret;
		v = y + 16'sd43;
		r = v[5:0] - 6'(div3(v[5:0])) * 6'd3;
		if (y <= -16'sd45) begin
			ret = (y[1:0] == 2'b00);
		end else if (y >= -16'sd43 && y <= -16'sd7) begin
			ret = (r == 6'd0);
		end else if (y >= 16'sd8) begin
			ret = (y[1:0] == 2'b00);
		end else begin
			ret = 1'b0;
		end
		return ret;
	endfunction

	// Leap days between 1 January 45 BC and 1 January of year y.
	function automatic yr_t leap_count(input yr_t y);
		yr_t k;
		yr_t t;
		yr_t ret;
		k = -(y + 16'sd44);
		t = y + 16'sd45;
		if (y <= -16'sd44) begin
			ret = -(k >>> 2);
		end else if (y <= -16'sd7) begin
			ret = yr_t'({1'b0, div3(t[5:0])});
		end else if (y <= 16'sd7) begin
			ret = 16'sd13;
		end else begin
			ret = 16'sd12 + ((y - 16'sd1) >>> 2);
		end
		return ret;
	endfunction

	// Days from 1 January 45 BC to 1 January of year y.
	function automatic dn_t year_start(input yr_t y);
		dn_t n;
		n = dn_t'(y) + 26'sd44;
		return n * 26'sd365 + dn_t'(leap_count(y));
	endfunction

	// Days before the first of month m in a common year.
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] ret;
		case (m)
			4'd1:    ret = 9'd0;
			4'd2:    ret = 9'd31;
			4'd3:    ret = 9'd59;
			4'd4:    ret = 9'd90;
			4'd5:    ret = 9'd120;
			4'd6:    ret = 9'd151;
			4'd7:    ret = 9'd181;
			4'd8:    ret = 9'd212;
			4'd9:    ret = 9'd243;
			4'd10:   ret = 9'd273;
			4'd11:   ret = 9'd304;
			4'd12:   ret = 9'd334;
			default: ret = 9'd0;
		endcase
		return ret;
	endfunction

endpackage

### hw/rtl/jdn_pipe_ctrl.sv
module jdn_pipe_ctrl import jdn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output pipe_ctrl_t ctrl
);

	logic [N_STAGES-1:0] vld_q;

	// A stage loads when it is empty or its word moves on in the same cycle.
	always_comb begin
		ctrl.en[N_STAGES-1] = !vld_q[N_STAGES-1] || out_ready;
		for (int i = N_STAGES - 2; i >= 0; i--) begin
			ctrl.en[i] = !vld_q[i] || ctrl.en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctrl.en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < N_STAGES; i++) begin
				if (ctrl.en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = ctrl.en[0];
	assign out_valid = vld_q[N_STAGES-1];

endmodule

### hw/rtl/jdn_date_path.sv
module jdn_date_path import jdn_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic               clk,
	input  pipe_ctrl_t         ctrl,
	input  logic               era,
	input  logic        [13:0] year,
	input  logic        [3:0]  month,
	input  logic        [4:0]  day,
	output logic signed [23:0] serial,
	output logic               bad,
	output logic               era_echo,
	output logic        [13:0] year_echo,
	output logic        [3:0]  month_echo,
	output logic        [4:0]  day_echo
);

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] ret;
		case (m)
			4'd2:    ret = lp ? 5'd29 : 5'd28;
			4'd4:    ret = 5'd30;
			4'd6:    ret = 5'd30;
			4'd9:    ret = 5'd30;
			4'd11:   ret = 5'd30;
			default: ret = 5'd31;
		endcase
		return ret;
	endfunction

	yr_t y_s1;
	logic bad_s1, bad_s2, bad_s3, bad_s4, bad_s5;
	logic era_s1, era_s2, era_s3, era_s4, era_s5;
	logic [13:0] year_s1, year_s2, year_s3, year_s4, year_s5;
	logic [3:0] month_s1, month_s2, month_s3, month_s4, month_s5;
	logic [4:0] day_s1, day_s2, day_s3, day_s4, day_s5;
	dn_t ys_s2;
	logic lp_s2;
	logic signed [23:0] s_s3;

	yr_t y_c;
	logic bad1_c, lp_c, bad2_c;
	dn_t s_c;

	always_comb begin
		y_c = era ? yr_t'({2'b00, year}) : 16'sd1 - yr_t'({2'b00, year});
		bad1_c = (year == 14'd0) || (32'(year) > MAX_YEAR) || (month == 4'd0)
			|| (month > 4'd12);
		lp_c = is_leap(y_s1);
		bad2_c = bad_s1 || (day_s1 == 5'd0) || (day_s1 > month_len(month_s1, lp_c));
		s_c = EPOCH_DAY + ys_s2 + dn_t'({17'd0, cum_days(month_s2)})
			+ dn_t'({25'd0, (lp_s2 && month_s2 > 4'd2)}) + dn_t'({21'd0, day_s2})
			- 26'sd1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			y_s1     <= y_c;
			bad_s1   <= bad1_c;
			era_s1   <= era;
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
		end
		if (ctrl.en[1]) begin
			ys_s2    <= year_start(y_s1);
			lp_s2    <= lp_c;
			bad_s2   <= bad2_c;
			era_s2   <= era_s1;
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
		end
		if (ctrl.en[2]) begin
			s_s3     <= s_c[23:0];
			bad_s3   <= bad_s2;
			era_s3   <= era_s2;
			year_s3  <= year_s2;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
		end
		if (ctrl.en[3]) begin
			bad_s4   <= bad_s3;
			era_s4   <= era_s3;
			year_s4  <= year_s3;
			month_s4 <= month_s3;
			day_s4   <= day_s3;
		end
		if (ctrl.en[4]) begin
			bad_s5   <= bad_s4;
			era_s5   <= era_s4;
			year_s5  <= year_s4;
			month_s5 <= month_s4;
			day_s5   <= day_s4;
		end
	end

	assign serial     = s_s3;
	assign bad        = bad_s5;
	assign era_echo   = era_s5;
	assign year_echo  = year_s5;
	assign month_echo = month_s5;
	assign day_echo   = day_s5;

endmodule

### hw/rtl/jdn_serial_path.sv
module jdn_serial_path import jdn_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic               clk,
	input  pipe_ctrl_t         ctrl,
	input  logic signed [23:0] serial_in,
	output logic signed [23:0] serial_echo,
	output logic               oor,
	output logic               era_out,
	output logic        [13:0] year_out,
	output logic        [3:0]  month_out,
	output logic        [4:0]  day_out
);

	// Floor of v / 1461 by reciprocal; exact for every v below 2**V_W.
	localparam int V_W     = 27;
	localparam int R_W     = 28;
	localparam int R_SHIFT = 38;
	localparam int Q_W     = 16;
	localparam int Q_BIAS  = 21000;
	localparam logic [R_W-1:0] RECIP = 28'd188143674;
	localparam logic signed [V_W:0] V_BIAS = 28'(1461 * Q_BIAS);
	localparam logic signed [Q_W:0] Y_BIAS = 17'(Q_BIAS + 44);

	dn_t d_s1, d_s2, d_s3;
	logic [V_W-1:0] v_s1;
	logic [Q_W-1:0] q_s2;
	logic signed [23:0] sin_s1, sin_s2, sin_s3;
	yr_t ye_s3;
	dn_t ysm_s3, ys0_s3, ysp_s3;
	logic [8:0] doy_s4;
	logic [14:0] ey_s4;
	logic era_s4, oor_s4, lp_s4;
	logic era_s5, oor_s5;
	logic [13:0] year_s5;
	logic [3:0] month_s5;
	logic [4:0] day_s5;

	dn_t d_c;
	logic signed [V_W:0] t_c;
	logic [V_W+R_W-1:0] prod_c;
	logic signed [Q_W:0] ye_w;
	yr_t ye_c;
	yr_t y_c;
	dn_t ys_c;
	dn_t doy_w;
	yr_t ey_c;
	logic [3:0] mon_c;
	logic [8:0] base_c;
	logic [8:0] dd_c;

	always_comb begin
		d_c = dn_t'(serial_in) - EPOCH_DAY;
		t_c = (28'(d_c) <<< 2) + V_BIAS;
		prod_c = 55'(v_s1) * 55'(RECIP);
		ye_w = signed'({1'b0, q_s2}) - Y_BIAS;
		ye_c = ye_w[15:0];
	end

	// The quotient estimate is at most one year off; one correction settles it.
	always_comb begin
		if (ys0_s3 > d_s3) begin
			y_c  = ye_s3 - 16'sd1;
			ys_c = ysm_s3;
		end else if (ysp_s3 <= d_s3) begin
			y_c  = ye_s3 + 16'sd1;
			ys_c = ysp_s3;
		end else begin
			y_c  = ye_s3;
			ys_c = ys0_s3;
		end
		doy_w = d_s3 - ys_c;
		ey_c = (y_c >= 16'sd1) ? y_c : 16'sd1 - y_c;
	end

	always_comb begin
		mon_c = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			base_c = cum_days(4'(i)) + {8'd0, (lp_s4 && i > 2)};
			if (base_c <= doy_s4) begin
				mon_c = 4'(i);
			end
		end
		dd_c = doy_s4 - cum_days(mon_c) - {8'd0, (lp_s4 && mon_c > 4'd2)} + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			d_s1   <= d_c;
			v_s1   <= t_c[V_W-1:0];
			sin_s1 <= serial_in;
		end
		if (ctrl.en[1]) begin
			d_s2   <= d_s1;
			q_s2   <= prod_c[R_SHIFT+Q_W-1:R_SHIFT];
			sin_s2 <= sin_s1;
		end
		if (ctrl.en[2]) begin
			d_s3   <= d_s2;
			ye_s3  <= ye_c;
			ysm_s3 <= year_start(ye_c - 16'sd1);
			ys0_s3 <= year_start(ye_c);
			ysp_s3 <= year_start(ye_c + 16'sd1);
			sin_s3 <= sin_s2;
		end
		if (ctrl.en[3]) begin
			doy_s4 <= doy_w[8:0];
			ey_s4  <= ey_c[14:0];
			era_s4 <= (y_c >= 16'sd1);
			oor_s4 <= (32'(ey_c[14:0]) > MAX_YEAR);
			lp_s4  <= is_leap(y_c);
		end
		if (ctrl.en[4]) begin
			era_s5   <= era_s4;
			oor_s5   <= oor_s4;
			year_s5  <= ey_s4[13:0];
			month_s5 <= mon_c;
			day_s5   <= dd_c[4:0];
		end
	end

	assign serial_echo = sin_s3;
	assign oor         = oor_s5;
	assign era_out     = era_s5;
	assign year_out    = year_s5;
	assign month_out   = month_s5;
	assign day_out     = day_s5;

endmodule

### hw/rtl/jdn_weekday.sv
module jdn_weekday import jdn_pkg::*; (
	input  logic               clk,
	input  pipe_ctrl_t         ctrl,
	input  logic signed [23:0] serial,
	output logic signed [23:0] serial_out,
	output logic        [2:0]  weekday
);

	// Serial day 0 is a Thursday; the bias is 4 plus a multiple of 7 that
	// makes every 24-bit serial non-negative.
	localparam logic [24:0] WD_BIAS = 25'd14680068;

	logic signed [23:0] w_s4, w_s5;
	logic [5:0] sum_s4;
	logic [2:0] wd_s5;

	logic [24:0] u_c;
	logic [5:0] sum_c;
	logic [3:0] a_c;
	logic [3:0] m_c;

	// Eight is one modulo seven, so the octal digits can simply be summed.
	always_comb begin
		u_c = 25'(serial) + WD_BIAS;
		sum_c = {5'd0, u_c[24]};
		for (int i = 0; i < 8; i++) begin
			sum_c = sum_c + {3'd0, u_c[3*i +: 3]};
		end
		a_c = {1'b0, sum_s4[5:3]} + {1'b0, sum_s4[2:0]};
		if (a_c >= 4'd14) begin
			m_c = a_c - 4'd14;
		end else if (a_c >= 4'd7) begin
			m_c = a_c - 4'd7;
		end else begin
			m_c = a_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			w_s4   <= serial;
			sum_s4 <= sum_c;
		end
		if (ctrl.en[4]) begin
			w_s5  <= w_s4;
			wd_s5 <= m_c[2:0];
		end
	end

	assign serial_out = w_s5;
	assign weekday    = wd_s5;

endmodule

### hw/rtl/julian_date_day_number_converter_unit.sv
// Julian calendar date / serial day number converter.
// Input words arrive on the s_axis channel: tuser selects the direction
// (0 turns the date fields into a serial day, 1 turns serial_in into a date)
// and tdata carries the date fields and serial_in. Every input word yields
// exactly one output word on the m_axis channel with the serial day, the
// date, the day of the week and an error code (1 for an invalid date,
// 2 for a serial whose year lies beyond MAX_YEAR in either era).
// The datapath is five register stages deep, and a new word can be accepted
// in every cycle while m_axis_tready is high. The stage count is set by the
// reciprocal multiply for the division by 1461 and the year-start evaluations
// that follow it.
// Reset clears every stage valid bit, so the pipeline comes up empty and
// ready. When m_axis_tready is low the words close up behind the held
// output word; s_axis_tready falls only once all five stages are full, and
// it follows m_axis_tready combinationally.
module julian_date_day_number_converter_unit import jdn_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// era[0], year[14:1], month[18:15], day[23:19], serial_in[47:24]
	input  logic [47:0] s_axis_tdata,
	// command[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// serial_out[23:0], era_out[24], year_out[38:25], month_out[42:39],
	// day_out[47:43], weekday[50:48], error_code[52:51], zero[55:53]
	output logic [55:0] m_axis_tdata
);

	pipe_ctrl_t ctrl;

	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;

	logic signed [23:0] date_serial;
	logic date_bad, date_era;
	logic [13:0] date_year;
	logic [3:0] date_month;
	logic [4:0] date_day;

	logic signed [23:0] sin_echo;
	logic inv_oor, inv_era;
	logic [13:0] inv_year;
	logic [3:0] inv_month;
	logic [4:0] inv_day;

	logic signed [23:0] wd_serial_in;
	logic signed [23:0] wd_serial;
	logic [2:0] wd_day;

	logic signed [23:0] serial_o;
	logic era_o;
	logic [13:0] year_o;
	logic [3:0] month_o;
	logic [4:0] day_o;
	logic [2:0] weekday_o;
	err_t err_o;

	jdn_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctrl      (ctrl)
	);

	jdn_date_path #(
		.MAX_YEAR (MAX_YEAR)
	) u_date (
		.clk        (clk),
		.ctrl       (ctrl),
		.era        (s_axis_tdata[0]),
		.year       (s_axis_tdata[14:1]),
		.month      (s_axis_tdata[18:15]),
		.day        (s_axis_tdata[23:19]),
		.serial     (date_serial),
		.bad        (date_bad),
		.era_echo   (date_era),
		.year_echo  (date_year),
		.month_echo (date_month),
		.day_echo   (date_day)
	);

	jdn_serial_path #(
		.MAX_YEAR (MAX_YEAR)
	) u_serial (
		.clk         (clk),
		.ctrl        (ctrl),
		.serial_in   (s_axis_tdata[47:24]),
		.serial_echo (sin_echo),
		.oor         (inv_oor),
		.era_out     (inv_era),
		.year_out    (inv_year),
		.month_out   (inv_month),
		.day_out     (inv_day)
	);

	assign wd_serial_in = (cmd_s3 == CMD_TO_DATE) ? sin_echo : date_serial;

	jdn_weekday u_weekday (
		.clk        (clk),
		.ctrl       (ctrl),
		.serial     (wd_serial_in),
		.serial_out (wd_serial),
		.weekday    (wd_day)
	);

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
		end
		if (ctrl.en[1]) begin
			cmd_s2 <= cmd_s1;
		end
		if (ctrl.en[2]) begin
			cmd_s3 <= cmd_s2;
		end
		if (ctrl.en[3]) begin
			cmd_s4 <= cmd_s3;
		end
		if (ctrl.en[4]) begin
			cmd_s5 <= cmd_s4;
		end
	end

	always_comb begin
		serial_o  = wd_serial;
		weekday_o = wd_day;
		era_o     = 1'b0;
		year_o    = '0;
		month_o   = '0;
		day_o     = '0;
		err_o     = ERR_OK;
		if (cmd_s5 == CMD_TO_SERIAL) begin
			if (date_bad) begin
				serial_o  = '0;
				weekday_o = '0;
				err_o     = ERR_DATE;
			end else begin
				era_o   = date_era;
				year_o  = date_year;
				month_o = date_month;
				day_o   = date_day;
			end
		end else begin
			if (inv_oor) begin
				err_o = ERR_RANGE;
			end else begin
				era_o   = inv_era;
				year_o  = inv_year;
				month_o = inv_month;
				day_o   = inv_day;
			end
		end
	end

	assign m_axis_tdata = {3'b000, err_o, weekday_o, day_o, month_o, year_o, era_o, serial_o};

endmodule
